/* design/tbpp_pkg.sv */
package tbpp_pkg;

  // Field widths of one transfer.
  localparam int TIME_W  = 64;
  localparam int START_W = 37;
  localparam int END_W   = 38;
  localparam int MASK_W  = 16;
  localparam int IN_W    = 176;
  localparam int OUT_W   = 40;

  // Item kinds carried on in_tuser.
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_QUERY  = 2'd3
  } tbpp_func_t;

  // Append status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_ORDER     = 2'd2,
    STAT_BAD_RANGE = 2'd3
  } tbpp_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN
  } tbpp_state_t;

  // One stored press.
  typedef struct packed {
    logic [START_W-1:0] start_us;
    logic [END_W-1:0]   end_us;
    logic [MASK_W-1:0]  mask;
  } tbpp_entry_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              skipping;
    logic              broken;
    logic [MASK_W-1:0] mask;
  } tbpp_tok_t;

endpackage

/* design/tbpp_cell.sv */
module tbpp_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int K     = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_idx,
  input  tbpp_pkg::tbpp_entry_t       wr_data,
  input  logic [CNT_W-1:0]            count,
  input  logic [CNT_W-1:0]            first_idx,
  input  logic [tbpp_pkg::TIME_W-1:0] elapsed,
  input  tbpp_pkg::tbpp_tok_t         tok_in,
  input  logic [CNT_W-1:0]            cur_in,
  output tbpp_pkg::tbpp_tok_t         tok_out,
  output logic [CNT_W-1:0]            cur_out
);
  import tbpp_pkg::*;

  tbpp_entry_t      entry_r;
  tbpp_tok_t        tok_r;
  tbpp_tok_t        tok_nxt;
  logic [CNT_W-1:0] cur_r;
  logic [CNT_W-1:0] cur_nxt;
  logic             live;
  logic             start_after;
  logic             end_passed;

  // The entry is written when an append lands on this slot.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(K))) begin
      entry_r <= wr_data;
    end
  end

  // Only entries between the scan start and the fill level take part.
  assign live        = (CNT_W'(K) < count) && (CNT_W'(K) >= first_idx);
  assign start_after = TIME_W'(entry_r.start_us) > elapsed;
  assign end_passed  = TIME_W'(entry_r.end_us) <= elapsed;

  // On a sample, skip finished presses first, then collect masks until a later start.
  always_comb begin
    tok_nxt = tok_in;
    cur_nxt = cur_in;
    if (tok_in.valid && live && !tok_in.broken) begin
      if (tok_in.skipping && end_passed) begin
        cur_nxt = CNT_W'(K + 1);
      end else begin
        tok_nxt.skipping = 1'b0;
        if (start_after) begin
          tok_nxt.broken = 1'b1;
        end else if (!end_passed) begin
          tok_nxt.mask = tok_in.mask | entry_r.mask;
        end
      end
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign tok_out = tok_r;
  assign cur_out = cur_r;

endmodule

/* design/timed_button_press_playback.sv */
// Channel | Direction | Handshake            | Contents
// in_     | input     | in_tvalid/in_tready   | tuser: func; tdata: time, press, pad sample
// out_    | output    | out_tvalid/out_tready | tdata: held mask, pad fields, status
//
// Clear, append, and a sample with an empty table give their result in the next cycle.
// A sample on a filled table and a query pass through the launch state: a token
// walks the row of press cells, one cell per cycle, then the result is registered.
// Reset empties the table and stops the run; the press cells need no clearing.
// A result waits in the output register while out_tready is low; a new item is
// taken in the idle state once that register is free or being drained.
module timed_button_press_playback #(
  parameter int MAX_PRESSES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] time_us, [100:64] press_start, [138:101] press_end,
  // [154:139] press_mask, [170:155] pad_buttons, [171] pad_connected,
  // [172] pad_intercepted, [175:173] zero
  input  logic [175:0] in_tdata,
  // [1:0] func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] held_mask, [31:16] pad_buttons_out, [32] pad_connected_out,
  // [33] pad_intercepted_out, [35:34] status, [39:36] zero
  output logic [39:0]  out_tdata
);
  import tbpp_pkg::*;

  localparam int IDX_W = (MAX_PRESSES > 1) ? $clog2(MAX_PRESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PRESSES + 1);

  // Input fields.
  tbpp_func_t         in_func;
  logic [TIME_W-1:0]  in_time;
  logic [START_W-1:0] in_start;
  logic [END_W-1:0]   in_end;
  logic [MASK_W-1:0]  in_mask;
  logic [MASK_W-1:0]  in_pb;
  logic               in_pc;
  logic               in_pi;

  assign in_func  = tbpp_func_t'(in_tuser);
  assign in_time  = in_tdata[63:0];
  assign in_start = in_tdata[100:64];
  assign in_end   = in_tdata[138:101];
  assign in_mask  = in_tdata[154:139];
  assign in_pb    = in_tdata[170:155];
  assign in_pc    = in_tdata[171];
  assign in_pi    = in_tdata[172];

  // Control and run state.
  tbpp_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cursor_r, cursor_nxt;
  logic               run_r, run_nxt;
  logic [TIME_W-1:0]  origin_r, origin_nxt;
  logic [START_W-1:0] last_start_r, last_start_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic               sample_r, sample_nxt;
  logic [MASK_W-1:0]  pb_r, pb_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  logic               in_xfer;
  logic               wr_en;
  tbpp_entry_t        wr_data;
  logic [TIME_W-1:0]  origin_sel;
  logic [CNT_W-1:0]   first_idx;
  tbpp_tok_t          tok_chain [0:MAX_PRESSES];
  logic [CNT_W-1:0]   cur_chain [0:MAX_PRESSES];
  tbpp_tok_t          tail_tok;
  logic [CNT_W-1:0]   tail_cur;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  assign wr_data.start_us = in_start;
  assign wr_data.end_us   = in_end;
  assign wr_data.mask     = in_mask;

  // A new run takes its origin from this sample.
  assign origin_sel = run_r ? origin_r : in_time;
  assign first_idx  = sample_r ? cursor_r : '0;

  // Token injected at the head of the row.
  always_comb begin
    tok_chain[0].valid    = (state_r == ST_LAUNCH);
    tok_chain[0].skipping = sample_r;
    tok_chain[0].broken   = 1'b0;
    tok_chain[0].mask     = '0;
    cur_chain[0]          = first_idx;
  end

  // Row of press cells.
  for (genvar k = 0; k < MAX_PRESSES; k++) begin : g_cell
    tbpp_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .K     (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_en),
      .wr_idx    (count_r[IDX_W-1:0]),
      .wr_data   (wr_data),
      .count     (count_r),
      .first_idx (first_idx),
      .elapsed   (elapsed_r),
      .tok_in    (tok_chain[k]),
      .cur_in    (cur_chain[k]),
      .tok_out   (tok_chain[k+1]),
      .cur_out   (cur_chain[k+1])
    );
  end

  assign tail_tok = tok_chain[MAX_PRESSES];
  assign tail_cur = cur_chain[MAX_PRESSES];

  // Next state, item decode and result assembly.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    run_nxt        = run_r;
    origin_nxt     = origin_r;
    last_start_nxt = last_start_r;
    elapsed_nxt    = elapsed_r;
    sample_nxt     = sample_r;
    pb_nxt         = pb_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_func)
            FUNC_CLEAR: begin
              count_nxt     = '0;
              cursor_nxt    = '0;
              run_nxt       = 1'b0;
              origin_nxt    = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
            FUNC_APPEND: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              if (count_r == CNT_W'(MAX_PRESSES)) begin
                out_data_nxt[35:34] = STAT_FULL;
              end else if ((count_r != '0) && (in_start < last_start_r)) begin
                out_data_nxt[35:34] = STAT_ORDER;
              end else if (in_end <= END_W'(in_start)) begin
                out_data_nxt[35:34] = STAT_BAD_RANGE;
              end else begin
                wr_en          = 1'b1;
                count_nxt      = count_r + 1'b1;
                last_start_nxt = in_start;
              end
            end
            FUNC_SAMPLE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = {4'b0, STAT_OK, in_pi, in_pc, in_pb, {MASK_W{1'b0}}};
              end else begin
                if (!run_r) begin
                  run_nxt    = 1'b1;
                  origin_nxt = in_time;
                  cursor_nxt = '0;
                end
                elapsed_nxt = (in_time >= origin_sel) ? (in_time - origin_sel) : '0;
                sample_nxt  = 1'b1;
                pb_nxt      = in_pb;
                state_nxt   = ST_LAUNCH;
              end
            end
            FUNC_QUERY: begin
              elapsed_nxt = in_time;
              sample_nxt  = 1'b0;
              state_nxt   = ST_LAUNCH;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // The output register is free by the time the token leaves the row.
        if (tail_tok.valid) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (sample_r) begin
            cursor_nxt   = tail_cur;
            out_data_nxt = {4'b0, STAT_OK, 1'b0, 1'b1, pb_r | tail_tok.mask, tail_tok.mask};
          end else begin
            out_data_nxt = {4'b0, STAT_OK, 1'b0, 1'b0, {MASK_W{1'b0}}, tail_tok.mask};
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      run_r       <= 1'b0;
      origin_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      run_r       <= run_nxt;
      origin_r    <= origin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    last_start_r <= last_start_nxt;
    elapsed_r    <= elapsed_nxt;
    sample_r     <= sample_nxt;
    pb_r         <= pb_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/tbpp_checker.sv */
module tbpp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [39:0]  out_tdata
);
  import tbpp_pkg::*;

  // A result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  // A clear gives an all-zero result in the next cycle.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_CLEAR) |=> out_tvalid && (out_tdata == '0))
    else $error("clear result wrong or late");

  // An append gives its status in the next cycle with no button data.
  a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_APPEND)
    |=> out_tvalid && (out_tdata[33:0] == '0))
    else $error("append result wrong or late");

  // A rejection status only comes with an otherwise empty result.
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[35:34] != STAT_OK) |-> (out_tdata[33:0] == '0))
    else $error("status with button data");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind timed_button_press_playback tbpp_checker u_tbpp_checker (.*);
